### rtl/core/lz78_pair_decoder_top_assert.svh
// ----------------------------------------------------------------------------
// LZ78 pair decoder assertion macros
// Concurrent assertion helpers; they compile to nothing when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef LZ78_PAIR_DECODER_TOP_ASSERT_SVH
`define LZ78_PAIR_DECODER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define LZ78PD_CHECK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define LZ78PD_CHECK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LZ78PD_CHECK(lbl, clk, rst_n, prop, msg)
`define LZ78PD_CHECK_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### rtl/core/lz78pd_pkg.sv
// ----------------------------------------------------------------------------
// LZ78 pair decoder package
// Sizes, field widths and the dictionary entry format.
// ----------------------------------------------------------------------------
`default_nettype none

package lz78pd_pkg;

	localparam int DICT_ENTRIES  = 255;
	localparam int MAX_ENTRY_LEN = 64;

	localparam int IDX_W  = 8;
	localparam int SYM_W  = 8;
	localparam int LEN_W  = 7;
	localparam int TOT_W  = LEN_W + 1;
	localparam int RB_AW  = $clog2(MAX_ENTRY_LEN);
	localparam int POS_W  = RB_AW + 1;

	typedef struct packed {
		logic [IDX_W-1:0] parent;
		logic [SYM_W-1:0] sym;
		logic [LEN_W-1:0] length;
	} dict_entry_t;

endpackage

`default_nettype wire

### rtl/core/lz78pd_if.sv
// ----------------------------------------------------------------------------
// LZ78 pair decoder channels
// Valid/ready channels for the incoming pairs and the decoded bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface lz78pd_pair_if;
	logic                          valid;
	logic                          ready;
	logic                          first_pair;
	logic [lz78pd_pkg::IDX_W-1:0] index_code;
	logic [lz78pd_pkg::SYM_W-1:0] symbol;

	modport source (output valid, first_pair, index_code, symbol, input ready);
	modport sink   (input valid, first_pair, index_code, symbol, output ready);
endinterface

interface lz78pd_byte_if;
	logic                          valid;
	logic                          ready;
	logic [lz78pd_pkg::SYM_W-1:0] out_byte;
	logic                          end_of_string;
	logic                          error;

	modport source (output valid, out_byte, end_of_string, error, input ready);
	modport sink   (input valid, out_byte, end_of_string, error, output ready);
endinterface

`default_nettype wire

### rtl/core/lz78_pair_decoder_top.sv
// ----------------------------------------------------------------------------
// LZ78 pair decoder
// Decodes (index, symbol) pairs into bytes and grows the dictionary.
// ----------------------------------------------------------------------------
//  Channel   Role    Fields
//  pair      sink    first_pair, index_code[7:0], symbol[7:0]
//  decoded   source  out_byte[7:0], end_of_string, error
//
//  For each pair, the parent chain is walked one entry per cycle through the single
//  dictionary read port, then the reverse buffer is read back one byte per cycle
//  while the output is not stalled. Error pairs go straight to the error state, or
//  through the length check when the prefix turns out too long. Reset clears the
//  dictionary count and the error flag; the memories are not cleared. A stalled
//  output holds the sequencer before the next byte is produced.
`default_nettype none
`include "lz78_pair_decoder_top_assert.svh"

module lz78_pair_decoder_top (
	input logic            clk,
	input logic            arst_n,
	lz78pd_pair_if.sink    pair,
	lz78pd_byte_if.source  decoded
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LEN,
		S_WALK,
		S_PRIME,
		S_EMIT,
		S_ERR
	} state_t;

	state_t                          state_q;
	logic [lz78pd_pkg::IDX_W-1:0]    count_q;
	logic                            failed_q;
	logic [lz78pd_pkg::IDX_W-1:0]    idx_q;
	logic [lz78pd_pkg::SYM_W-1:0]    sym_q;
	logic [lz78pd_pkg::IDX_W-1:0]    node_q;
	logic [lz78pd_pkg::POS_W-1:0]    pos_q;
	logic [lz78pd_pkg::POS_W-1:0]    total_q;
	logic [lz78pd_pkg::RB_AW-1:0]    rd_ptr_q;
	logic                            out_valid_q;
	logic [lz78pd_pkg::SYM_W-1:0]    out_byte_q;
	logic                            eos_q;
	logic                            err_q;

	lz78pd_pkg::dict_entry_t         dict_mem [lz78pd_pkg::DICT_ENTRIES];
	lz78pd_pkg::dict_entry_t         mem_q;
	logic [lz78pd_pkg::SYM_W-1:0]    rb_mem [lz78pd_pkg::MAX_ENTRY_LEN];
	logic [lz78pd_pkg::SYM_W-1:0]    rb_q;

	logic                            pair_fire;
	logic                            out_free;
	logic                            out_load;
	logic [lz78pd_pkg::IDX_W-1:0]    count_eff;
	logic                            failed_eff;
	logic                            bad_index;
	logic [lz78pd_pkg::TOT_W-1:0]    walk_len;
	logic                            overlong;
	logic [lz78pd_pkg::POS_W-1:0]    cur_total;
	logic [lz78pd_pkg::POS_W-1:0]    pos_nxt;
	logic [lz78pd_pkg::IDX_W-1:0]    dict_raddr;
	logic                            dict_we;
	logic                            rb_we;
	logic [lz78pd_pkg::RB_AW-1:0]    rb_waddr;
	logic [lz78pd_pkg::SYM_W-1:0]    rb_wdata;
	logic [lz78pd_pkg::RB_AW-1:0]    rb_raddr;

	assign pair_fire  = pair.valid && pair.ready;
	assign pair.ready = (state_q == S_IDLE);
	assign out_free   = !out_valid_q || decoded.ready;
	assign out_load   = (state_q == S_EMIT || state_q == S_ERR) && out_free;

	assign count_eff  = pair.first_pair ? '0 : count_q;
	assign failed_eff = pair.first_pair ? 1'b0 : failed_q;
	assign bad_index  = (pair.index_code != '0) && (pair.index_code > count_eff);

	assign walk_len  = {1'b0, mem_q.length} + lz78pd_pkg::TOT_W'(1);
	assign overlong  = walk_len > lz78pd_pkg::TOT_W'(lz78pd_pkg::MAX_ENTRY_LEN);
	assign cur_total = (state_q == S_LEN) ? walk_len[lz78pd_pkg::POS_W-1:0] : total_q;
	assign pos_nxt   = pos_q + lz78pd_pkg::POS_W'(1);

	assign dict_raddr = (state_q == S_IDLE) ?
		(pair.index_code - lz78pd_pkg::IDX_W'(1)) :
		(mem_q.parent - lz78pd_pkg::IDX_W'(1));

	assign dict_we = (state_q == S_EMIT) && out_free && (rd_ptr_q == '0) &&
		(count_q < lz78pd_pkg::IDX_W'(lz78pd_pkg::DICT_ENTRIES));

	always_comb begin
		rb_we    = 1'b0;
		rb_waddr = pos_q[lz78pd_pkg::RB_AW-1:0];
		rb_wdata = (node_q != '0) ? mem_q.sym : '0;
		if (state_q == S_IDLE) begin
			rb_we    = pair_fire;
			rb_waddr = '0;
			rb_wdata = pair.symbol;
		end else if ((state_q == S_LEN && !overlong) || state_q == S_WALK) begin
			rb_we = (pos_q < cur_total);
		end
	end

	assign rb_raddr = (state_q == S_EMIT && out_free) ?
		(rd_ptr_q - lz78pd_pkg::RB_AW'(1)) : rd_ptr_q;

	always_ff @(posedge clk) begin
		if (dict_we) begin
			dict_mem[count_q] <= '{parent: idx_q, sym: sym_q,
				length: lz78pd_pkg::LEN_W'(total_q)};
		end
		mem_q <= dict_mem[dict_raddr];
	end

	always_ff @(posedge clk) begin
		if (rb_we) begin
			rb_mem[rb_waddr] <= rb_wdata;
		end
		rb_q <= rb_mem[rb_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			failed_q    <= 1'b0;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
			sym_q       <= '0;
			node_q      <= '0;
			pos_q       <= '0;
			total_q     <= '0;
			rd_ptr_q    <= '0;
			out_byte_q  <= '0;
			eos_q       <= 1'b0;
			err_q       <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (decoded.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pair_fire) begin
						idx_q  <= pair.index_code;
						sym_q  <= pair.symbol;
						node_q <= pair.index_code;
						pos_q  <= lz78pd_pkg::POS_W'(1);
						if (pair.first_pair) begin
							count_q  <= '0;
							failed_q <= 1'b0;
						end
						if (failed_eff || bad_index) begin
							state_q <= S_ERR;
						end else if (pair.index_code == '0) begin
							total_q  <= lz78pd_pkg::POS_W'(1);
							rd_ptr_q <= '0;
							state_q  <= S_PRIME;
						end else begin
							state_q <= S_LEN;
						end
					end
				end
				S_LEN, S_WALK: begin
					if (state_q == S_LEN && overlong) begin
						state_q <= S_ERR;
					end else begin
						total_q <= cur_total;
						if (pos_q < cur_total) begin
							pos_q  <= pos_nxt;
							node_q <= (node_q != '0) ? mem_q.parent : '0;
						end
						if (pos_q >= cur_total || pos_nxt == cur_total) begin
							rd_ptr_q <= lz78pd_pkg::RB_AW'(cur_total - lz78pd_pkg::POS_W'(1));
							state_q  <= S_PRIME;
						end else begin
							state_q <= S_WALK;
						end
					end
				end
				S_PRIME: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						out_byte_q  <= rb_q;
						eos_q       <= (rd_ptr_q == '0);
						err_q       <= 1'b0;
						if (rd_ptr_q == '0) begin
							if (dict_we) begin
								count_q <= count_q + lz78pd_pkg::IDX_W'(1);
							end
							state_q <= S_IDLE;
						end else begin
							rd_ptr_q <= rd_ptr_q - lz78pd_pkg::RB_AW'(1);
						end
					end
				end
				S_ERR: begin
					if (out_free) begin
						out_byte_q  <= '0;
						eos_q       <= 1'b1;
						err_q       <= 1'b1;
						failed_q    <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign decoded.valid         = out_valid_q;
	assign decoded.out_byte      = out_byte_q;
	assign decoded.end_of_string = eos_q;
	assign decoded.error         = err_q;

	`LZ78PD_CHECK(a_count_bound, clk, arst_n, count_q <= lz78pd_pkg::IDX_W'(lz78pd_pkg::DICT_ENTRIES), "Dictionary count beyond capacity.")
	`LZ78PD_CHECK(a_walk_pos, clk, arst_n, (state_q != S_WALK) || (pos_q < total_q), "Chain walk ran past the string length.")
	`LZ78PD_CHECK_NEXT(a_err_sticky, clk, arst_n, state_q == S_ERR && out_free, failed_q && decoded.valid && decoded.error, "Error item did not set the sticky error.")
	`LZ78PD_CHECK_NEXT(a_failed_pair, clk, arst_n, pair_fire && failed_q && !pair.first_pair, state_q == S_ERR, "Pair in a failed message was decoded.")

endmodule

`default_nettype wire
